### hw/rtl/tbr_pkg.sv
// Shared constants, payload types and helper functions of the bar boundary round-up block.
package tbr_pkg;

  localparam int STAMP_W    = 55;
  localparam int PERIOD_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int BCD_DIGITS = 17;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int V_W        = 19;
  localparam int REM_W      = PERIOD_W;

  localparam int BCD_STEPS_PER_STAGE = 8;
  localparam int BCD_STAGES = (STAMP_W + BCD_STEPS_PER_STAGE - 1) / BCD_STEPS_PER_STAGE;

  localparam logic [CFG_IDX_W-1:0] REG_BAR_PERIOD      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_IS_SECONDS = 1'd1;

  localparam logic [PERIOD_W-1:0] MINUTES_PER_DAY = 17'd1440;
  localparam logic [PERIOD_W-1:0] SECONDS_PER_DAY = 17'd86400;

  typedef struct packed {
    logic [STAMP_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } bcd_word_t;

  typedef struct packed {
    logic [V_W-1:0]      v;
    logic [PERIOD_W-1:0] p;
    logic                sec_mode;
    logic [6:0]          day;
    logic [6:0]          month;
    logic [6:0]          ylo;
    logic [6:0]          yhi;
    logic [REM_W-1:0]    r;
  } rem_word_t;

  typedef struct packed {
    logic [STAMP_W-1:0] boundary_stamp;
    logic               rolled_to_next_day;
  } result_t;

  // One double-dabble step: correct every digit, then shift in the next binary bit.
  function automatic bcd_word_t bcd_step(bcd_word_t w);
    bcd_word_t        o;
    logic [BCD_W-1:0] adj;
    adj = w.bcd;
    for (int d = 0; d < BCD_DIGITS; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    o.bcd = {adj[BCD_W-2:0], w.bin[STAMP_W-1]};
    o.bin = {w.bin[STAMP_W-2:0], 1'b0};
    return o;
  endfunction

  function automatic logic [6:0] digit_pair(logic [3:0] hi, logic [3:0] lo);
    return {3'b000, hi} * 7'd10 + {3'b000, lo};
  endfunction

endpackage

### hw/rtl/tbr_if.sv
// Stream interfaces for the timestamp input and the boundary result.
interface tbr_in_if;
  logic                         valid;
  logic                         ready;
  logic [tbr_pkg::STAMP_W-1:0]  stamp_in;
  modport source (output valid, output stamp_in, input ready);
  modport sink   (input valid, input stamp_in, output ready);
endinterface

interface tbr_out_if;
  logic                         valid;
  logic                         ready;
  logic [tbr_pkg::STAMP_W-1:0]  boundary_stamp;
  logic                         rolled_to_next_day;
  modport source (output valid, output boundary_stamp, output rolled_to_next_day, input ready);
  modport sink   (input valid, input boundary_stamp, input rolled_to_next_day, output ready);
endinterface

### hw/rtl/tbr_bcd_stage.sv
// One pipeline stage of the binary to decimal digit conversion.
module tbr_bcd_stage #(
  parameter int STEPS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbr_pkg::bcd_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbr_pkg::bcd_word_t out_data
);

  logic               valid_r;
  tbr_pkg::bcd_word_t data_r;
  tbr_pkg::bcd_word_t data_nxt;

  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < STEPS; i++) begin
      data_nxt = tbr_pkg::bcd_step(data_nxt);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hw/rtl/tbr_fields.sv
// Stage that turns decimal digits into the time value in the bar unit and the date fields.
module tbr_fields (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [tbr_pkg::PERIOD_W-1:0] bar_period,
  input  logic                         unit_is_seconds,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tbr_pkg::bcd_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tbr_pkg::rem_word_t           out_data
);

  logic                    valid_r;
  tbr_pkg::rem_word_t      data_r;
  tbr_pkg::rem_word_t      data_nxt;
  logic [6:0]              sec, min, hour;
  logic                    ms_nz;
  logic [tbr_pkg::V_W-1:0] v_sec, v_min;
  logic [tbr_pkg::PERIOD_W-1:0] per;

  always_comb begin
    ms_nz = (in_data.bcd[11:0] != 12'd0);
    sec   = tbr_pkg::digit_pair(in_data.bcd[19:16], in_data.bcd[15:12]);
    min   = tbr_pkg::digit_pair(in_data.bcd[27:24], in_data.bcd[23:20]);
    hour  = tbr_pkg::digit_pair(in_data.bcd[35:32], in_data.bcd[31:28]);

    v_sec = 19'(hour) * 19'd3600 + 19'(min) * 19'd60 + 19'(sec) + 19'(ms_nz);
    v_min = 19'(hour) * 19'd60 + 19'(min) + 19'(ms_nz || (sec != 7'd0));

    // A zero period behaves as one; minute bars never exceed a day.
    per = (bar_period == '0) ? 17'd1 : bar_period;
    if (!unit_is_seconds && per > tbr_pkg::MINUTES_PER_DAY) begin
      per = tbr_pkg::MINUTES_PER_DAY;
    end

    data_nxt.v        = unit_is_seconds ? v_sec : v_min;
    data_nxt.p        = per;
    data_nxt.sec_mode = unit_is_seconds;
    data_nxt.day      = tbr_pkg::digit_pair(in_data.bcd[43:40], in_data.bcd[39:36]);
    data_nxt.month    = tbr_pkg::digit_pair(in_data.bcd[51:48], in_data.bcd[47:44]);
    data_nxt.ylo      = tbr_pkg::digit_pair(in_data.bcd[59:56], in_data.bcd[55:52]);
    data_nxt.yhi      = tbr_pkg::digit_pair(in_data.bcd[67:64], in_data.bcd[63:60]);
    data_nxt.r        = '0;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hw/rtl/tbr_rem_stage.sv
// One pipeline stage of the restoring remainder of the time value by the bar period.
module tbr_rem_stage #(
  parameter int FIRST_BIT = 18,
  parameter int STEPS     = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbr_pkg::rem_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbr_pkg::rem_word_t out_data
);

  logic                      valid_r;
  tbr_pkg::rem_word_t        data_r;
  tbr_pkg::rem_word_t        data_nxt;
  logic [tbr_pkg::REM_W:0]   t;

  always_comb begin
    data_nxt = in_data;
    t        = '0;
    for (int i = 0; i < STEPS; i++) begin
      t = {data_nxt.r, data_nxt.v[FIRST_BIT - i]};
      if (t >= {1'b0, data_nxt.p}) begin
        t = t - {1'b0, data_nxt.p};
      end
      data_nxt.r = t[tbr_pkg::REM_W-1:0];
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### hw/rtl/tbr_finish.sv
// Ceiling, day rollover, calendar step and decimal repacking over five stages.
module tbr_finish (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tbr_pkg::rem_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbr_pkg::result_t   out_data
);

  typedef struct packed {
    logic [tbr_pkg::V_W-1:0] x;
    logic                    rolled;
    logic [6:0]              day;
    logic [6:0]              month;
    logic [13:0]             year;
  } c_t;

  typedef struct packed {
    logic [6:0]  hh;
    logic [11:0] r1;
    logic [26:0] date;
    logic        rolled;
  } d_t;

  typedef struct packed {
    logic [6:0]                  hh;
    logic [5:0]                  mm;
    logic [5:0]                  ss;
    logic [tbr_pkg::STAMP_W-1:0] dh;
    logic                        rolled;
  } e_t;

  typedef struct packed {
    logic [31:0]                 t;
    logic [tbr_pkg::STAMP_W-1:0] dh;
    logic                        rolled;
  } f_t;

  logic vc_r, vd_r, ve_r, vf_r, vg_r;
  logic rc, rd, re, rf, rg;
  c_t   c_r, c_nxt;
  d_t   d_r, d_nxt;
  e_t   e_r, e_nxt;
  f_t   f_r, f_nxt;
  tbr_pkg::result_t g_r, g_nxt;

  logic [19:0]                  ceil_v, day_len;
  logic [tbr_pkg::V_W-1:0]      c2;
  logic [24:0]                  c2_min;
  logic [13:0]                  year_in;
  logic                         leap;
  logic [6:0]                   mlen;
  logic [tbr_pkg::V_W-1:0]      rh;
  logic [11:0]                  rm;
  logic [27:0]                  date_w;
  logic [56:0]                  dh_w;

  // Stage C: ceiling to the period, rollover and the next calendar day.
  always_comb begin
    if (in_data.r == '0) begin
      ceil_v = {1'b0, in_data.v};
    end else begin
      ceil_v = {1'b0, in_data.v} + {3'b000, in_data.p} - {3'b000, in_data.r};
    end
    day_len  = in_data.sec_mode ? {3'b000, tbr_pkg::SECONDS_PER_DAY}
                                : {3'b000, tbr_pkg::MINUTES_PER_DAY};
    c_nxt.rolled = (ceil_v >= day_len);
    c2 = c_nxt.rolled ? 19'(ceil_v - day_len) : ceil_v[tbr_pkg::V_W-1:0];
    c2_min = 25'(c2) * 25'd60;
    c_nxt.x = in_data.sec_mode ? c2 : c2_min[tbr_pkg::V_W-1:0];

    year_in = 14'(in_data.yhi) * 14'd100 + 14'(in_data.ylo);
    leap = ((in_data.ylo[1:0] == 2'b00) && (in_data.ylo != 7'd0)) ||
           ((in_data.ylo == 7'd0) && (in_data.yhi[1:0] == 2'b00));
    if (in_data.month == 7'd2) begin
      mlen = leap ? 7'd29 : 7'd28;
    end else if (in_data.month inside {7'd4, 7'd6, 7'd9, 7'd11}) begin
      mlen = 7'd30;
    end else begin
      mlen = 7'd31;
    end

    c_nxt.day   = in_data.day;
    c_nxt.month = in_data.month;
    c_nxt.year  = year_in;
    if (c_nxt.rolled) begin
      if (in_data.day < mlen) begin
        c_nxt.day = in_data.day + 7'd1;
      end else begin
        c_nxt.day = 7'd1;
        // Any month of twelve or more wraps into the next year.
        if (in_data.month >= 7'd12) begin
          c_nxt.month = 7'd1;
          c_nxt.year  = year_in + 14'd1;
        end else begin
          c_nxt.month = in_data.month + 7'd1;
        end
      end
    end
  end

  // Stage D: hours by restoring steps, packed date in binary.
  always_comb begin
    rh = c_r.x;
    d_nxt.hh = '0;
    for (int k = 6; k >= 0; k--) begin
      if (rh >= (19'd3600 << k)) begin
        rh = rh - (19'd3600 << k);
        d_nxt.hh[k] = 1'b1;
      end
    end
    d_nxt.r1 = rh[11:0];
    date_w = 28'(c_r.year) * 28'd10000 + 28'(c_r.month) * 28'd100 + 28'(c_r.day);
    d_nxt.date   = date_w[26:0];
    d_nxt.rolled = c_r.rolled;
  end

  // Stage E: minutes and seconds, date scaled to its decimal position.
  always_comb begin
    rm = d_r.r1;
    e_nxt.mm = '0;
    for (int k = 5; k >= 0; k--) begin
      if (rm >= (12'd60 << k)) begin
        rm = rm - (12'd60 << k);
        e_nxt.mm[k] = 1'b1;
      end
    end
    e_nxt.ss = rm[5:0];
    e_nxt.hh = d_r.hh;
    dh_w = 57'(d_r.date) * 57'd1_000_000_000;
    e_nxt.dh = dh_w[tbr_pkg::STAMP_W-1:0];
    e_nxt.rolled = d_r.rolled;
  end

  // Stage F: time of day in decimal positions.
  always_comb begin
    f_nxt.t = 32'(e_r.hh) * 32'd10_000_000 + 32'(e_r.mm) * 32'd100_000 +
              32'(e_r.ss) * 32'd1000;
    f_nxt.dh     = e_r.dh;
    f_nxt.rolled = e_r.rolled;
  end

  // Stage G: final sum into the output register.
  always_comb begin
    g_nxt.boundary_stamp     = f_r.dh + 55'(f_r.t);
    g_nxt.rolled_to_next_day = f_r.rolled;
  end

  assign rg = !vg_r || out_ready;
  assign rf = !vf_r || rg;
  assign re = !ve_r || rf;
  assign rd = !vd_r || re;
  assign rc = !vc_r || rd;
  assign in_ready = rc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      if (rc) vc_r <= in_valid;
      if (rd) vd_r <= vc_r;
      if (re) ve_r <= vd_r;
      if (rf) vf_r <= ve_r;
      if (rg) vg_r <= vf_r;
    end
    if (rc) c_r <= c_nxt;
    if (rd) d_r <= d_nxt;
    if (re) e_r <= e_nxt;
    if (rf) f_r <= f_nxt;
    if (rg) g_r <= g_nxt;
  end

  assign out_valid = vg_r;
  assign out_data  = g_r;

endmodule

### hw/rtl/time_bucket_boundary_round_up.sv
// Top level of the bar boundary round-up pipeline.
//
// Rounds a decimal packed YYYYMMDDHHMMSSmmm timestamp up to the next bar boundary of
// bar_period minutes or seconds, moving to the next calendar day when the boundary reaches
// midnight. The pipeline takes one word per clock while the output side does not stall;
// seven stages convert the 55-bit input to decimal digits up to eight bits at a time,
// one stage forms the time value, three stages run the 19-step remainder by the period,
// and five stages do the ceiling, calendar and repacking. Empty stages fill while a result
// waits, so a stall only holds what is queued. Configuration is written through cfg_we;
// the user must write it only while the pipeline is empty; the block does not check it.
module time_bucket_boundary_round_up (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbr_pkg::PERIOD_W-1:0]  cfg_data,
  tbr_in_if.sink                        in_ch,
  tbr_out_if.source                     out_ch
);

  localparam int NB = tbr_pkg::BCD_STAGES;

  logic [tbr_pkg::PERIOD_W-1:0] bar_period_r;
  logic                         unit_is_seconds_r;

  logic               bcd_valid [NB+1];
  logic               bcd_ready [NB+1];
  tbr_pkg::bcd_word_t bcd_data  [NB+1];

  logic               rem_valid [4];
  logic               rem_ready [4];
  tbr_pkg::rem_word_t rem_data  [4];

  tbr_pkg::result_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_period_r      <= 17'd1;
      unit_is_seconds_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == tbr_pkg::REG_BAR_PERIOD) begin
        bar_period_r <= cfg_data;
      end else if (cfg_index == tbr_pkg::REG_UNIT_IS_SECONDS) begin
        unit_is_seconds_r <= cfg_data[0];
      end
    end
  end

  assign bcd_valid[0]    = in_ch.valid;
  assign in_ch.ready     = bcd_ready[0];
  assign bcd_data[0].bin = in_ch.stamp_in;
  assign bcd_data[0].bcd = '0;

  for (genvar g = 0; g < NB; g++) begin : g_bcd
    localparam int STEPS = (g < NB - 1) ? tbr_pkg::BCD_STEPS_PER_STAGE
                         : tbr_pkg::STAMP_W - tbr_pkg::BCD_STEPS_PER_STAGE * (NB - 1);
    tbr_bcd_stage #(.STEPS(STEPS)) u_bcd (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (bcd_valid[g]),
      .in_ready  (bcd_ready[g]),
      .in_data   (bcd_data[g]),
      .out_valid (bcd_valid[g+1]),
      .out_ready (bcd_ready[g+1]),
      .out_data  (bcd_data[g+1])
    );
  end

  tbr_fields u_fields (
    .clk             (clk),
    .rst_n           (rst_n),
    .bar_period      (bar_period_r),
    .unit_is_seconds (unit_is_seconds_r),
    .in_valid        (bcd_valid[NB]),
    .in_ready        (bcd_ready[NB]),
    .in_data         (bcd_data[NB]),
    .out_valid       (rem_valid[0]),
    .out_ready       (rem_ready[0]),
    .out_data        (rem_data[0])
  );

  tbr_rem_stage #(.FIRST_BIT(18), .STEPS(7)) u_rem0 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(rem_valid[0]), .in_ready(rem_ready[0]), .in_data(rem_data[0]),
    .out_valid(rem_valid[1]), .out_ready(rem_ready[1]), .out_data(rem_data[1])
  );

  tbr_rem_stage #(.FIRST_BIT(11), .STEPS(6)) u_rem1 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(rem_valid[1]), .in_ready(rem_ready[1]), .in_data(rem_data[1]),
    .out_valid(rem_valid[2]), .out_ready(rem_ready[2]), .out_data(rem_data[2])
  );

  tbr_rem_stage #(.FIRST_BIT(5), .STEPS(6)) u_rem2 (
    .clk(clk), .rst_n(rst_n),
    .in_valid(rem_valid[2]), .in_ready(rem_ready[2]), .in_data(rem_data[2]),
    .out_valid(rem_valid[3]), .out_ready(rem_ready[3]), .out_data(rem_data[3])
  );

  tbr_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rem_valid[3]),
    .in_ready  (rem_ready[3]),
    .in_data   (rem_data[3]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (res)
  );

  assign out_ch.boundary_stamp     = res.boundary_stamp;
  assign out_ch.rolled_to_next_day = res.rolled_to_next_day;

  // With no word in the output register every stage can move, so the input must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input blocked while output register is empty");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_period_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == tbr_pkg::REG_BAR_PERIOD) |=> bar_period_r == $past(cfg_data))
    else $error("bar period write lost");

endmodule
